### hdl/kprr_pkg.sv
// Shared types and constants for the keypad press/repeat reporter.
package kprr_pkg;

    // Key index space covered by the two keymap registers.
    localparam int KEY_IDX_W = 4;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYMAP_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYMAP_HIGH = 2'd3;

    // Reset values.
    localparam logic [15:0] DEBOUNCE_RST    = 16'd50;
    localparam logic [15:0] REPEAT_RST      = 16'd500;
    localparam logic [63:0] KEYMAP_LOW_RST  = 64'h0000_0000_0706_0504;
    localparam logic [63:0] KEYMAP_HIGH_RST = 64'h0;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_REPEAT  = 2'd1,
        KIND_RELEASE = 2'd2
    } t_kind;

    // Word carried from the front end to the back end.
    typedef struct packed {
        logic [KEY_IDX_W-1:0] key_idx;
        t_kind                kind;
    } t_qword;

endpackage

### hdl/kprr_front.sv
// Front end: per-key state, debounce/repeat decision, event push.
module kprr_front #(
    parameter int ROWS = 2,
    parameter int COLS = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_key_row,
    input  logic [1:0]                        i_key_col,
    input  logic                              i_pressed,
    input  logic [kprr_pkg::TIME_W-1:0]       i_now_ms,
    input  logic [15:0]                       i_debounce_ms,
    input  logic [15:0]                       i_repeat_ms,
    input  logic                              i_q_ready,
    output logic                              o_push,
    output kprr_pkg::t_qword                  o_word
);

    localparam int NKEYS = ROWS * COLS;
    localparam int IDX_W = (NKEYS > 1) ? $clog2(NKEYS) : 1;

    logic                           r_held [NKEYS];
    logic [kprr_pkg::TIME_W-1:0]    r_last [NKEYS];

    logic [kprr_pkg::KEY_IDX_W-1:0] w_key_idx;
    logic [IDX_W-1:0]               w_idx;
    logic                           w_in_range;
    logic                           w_held;
    logic [kprr_pkg::TIME_W-1:0]    w_elapsed;
    logic                           w_past_debounce;
    logic                           w_past_repeat;
    logic                           w_event;
    kprr_pkg::t_kind                w_kind;
    logic                           w_accept;

    assign w_key_idx  = kprr_pkg::KEY_IDX_W'(i_key_row) * kprr_pkg::KEY_IDX_W'(COLS)
                      + kprr_pkg::KEY_IDX_W'(i_key_col);
    assign w_idx      = w_key_idx[IDX_W-1:0];
    assign w_in_range = (3'(i_key_row) < 3'(ROWS)) && (3'(i_key_col) < 3'(COLS));

    assign w_held          = r_held[w_idx];
    assign w_elapsed       = i_now_ms - r_last[w_idx];
    assign w_past_debounce = w_elapsed > {16'd0, i_debounce_ms};
    assign w_past_repeat   = w_elapsed > {16'd0, i_repeat_ms};

    always_comb begin
        w_event = 1'b0;
        w_kind  = kprr_pkg::KIND_PRESS;
        if (i_pressed) begin
            if (!w_held) begin
                w_event = w_past_debounce;
                w_kind  = kprr_pkg::KIND_PRESS;
            end else begin
                w_event = w_past_repeat;
                w_kind  = kprr_pkg::KIND_REPEAT;
            end
        end else begin
            w_event = w_held;
            w_kind  = kprr_pkg::KIND_RELEASE;
        end
    end

    assign o_ready  = i_q_ready;
    assign w_accept = i_valid && i_q_ready;
    assign o_push   = w_accept && w_in_range && w_event;

    assign o_word.key_idx = w_key_idx;
    assign o_word.kind    = w_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NKEYS; k++) begin
                r_held[k] <= 1'b0;
                r_last[k] <= '0;
            end
        end else if (o_push) begin
            // release clears the flag but keeps the last event time
            r_held[w_idx] <= (w_kind != kprr_pkg::KIND_RELEASE);
            if (w_kind != kprr_pkg::KIND_RELEASE) begin
                r_last[w_idx] <= i_now_ms;
            end
        end
    end

endmodule

### hdl/kprr_queue.sv
// Two-entry queue between the front end and the back end.
module kprr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  kprr_pkg::t_qword i_word,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_pop,
    output kprr_pkg::t_qword o_word
);

    kprr_pkg::t_qword r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_word  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule

### hdl/kprr_back.sv
// Back end: keycode lookup and output register.
module kprr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_pop,
    input  kprr_pkg::t_qword i_word,
    input  logic [127:0]     i_keymap,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_keycode,
    output logic [1:0]       o_event_kind
);

    logic            r_valid;
    logic [7:0]      r_keycode;
    kprr_pkg::t_kind r_kind;
    logic [7:0]      w_code;

    assign o_pop  = i_q_valid && (!r_valid || i_ready);
    assign w_code = (i_word.kind == kprr_pkg::KIND_RELEASE) ? 8'd0
                  : i_keymap[{i_word.key_idx, 3'b000} +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_keycode <= w_code;
            r_kind    <= i_word.kind;
        end
    end

    assign o_valid      = r_valid;
    assign o_keycode    = r_keycode;
    assign o_event_kind = r_kind;

endmodule

### hdl/keypad_press_repeat_reporter_core.sv
// Top level of the keypad press/repeat reporter.
//
// Takes key sample words (row, column, pressed level, millisecond time) and
// emits zero or one report word per sample: an initial press once more than
// debounce_ms has passed since the key's last press or repeat, a repeat
// every time more than repeat_ms has passed while the key is held, and a
// release (keycode zero) when a held key lets go. Time differences wrap
// modulo 2^32. Samples for keys outside the ROWS x COLS matrix are dropped.
// Rate: one sample word per cycle while the queue has room. The per-key
// decision is one 32-bit subtract and compare against flip-flop state, so
// the next sample, even for the same key, sees the updated state in the
// following cycle. A report passes through the two-entry event queue, then
// the output register where the keycode is looked up. Output stalls back up
// into the queue; input ready drops only when the queue is full. The user
// must write configuration through the plain write port only while the
// block is idle; the block itself does not enforce this.
module keypad_press_repeat_reporter_core #(
    parameter int ROWS = 2,
    parameter int COLS = 2
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [kprr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [kprr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // sample input
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_key_row,
    input  logic [1:0]                           i_key_col,
    input  logic                                 i_pressed,
    input  logic [kprr_pkg::TIME_W-1:0]          i_now_ms,
    // report output
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [7:0]                           o_keycode,
    output logic [1:0]                           o_event_kind
);

    // configuration registers
    logic [15:0] r_debounce_ms;
    logic [15:0] r_repeat_ms;
    logic [63:0] r_keymap_low;
    logic [63:0] r_keymap_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= kprr_pkg::DEBOUNCE_RST;
            r_repeat_ms   <= kprr_pkg::REPEAT_RST;
            r_keymap_low  <= kprr_pkg::KEYMAP_LOW_RST;
            r_keymap_high <= kprr_pkg::KEYMAP_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kprr_pkg::CFG_DEBOUNCE:    r_debounce_ms <= i_cfg_data[15:0];
                kprr_pkg::CFG_REPEAT:      r_repeat_ms   <= i_cfg_data[15:0];
                kprr_pkg::CFG_KEYMAP_LOW:  r_keymap_low  <= i_cfg_data;
                kprr_pkg::CFG_KEYMAP_HIGH: r_keymap_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front end -> queue
    logic             w_push;
    logic             w_q_ready;
    kprr_pkg::t_qword w_push_word;

    // queue -> back end
    logic             w_q_valid;
    logic             w_pop;
    kprr_pkg::t_qword w_head_word;

    kprr_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_key_row     (i_key_row),
        .i_key_col     (i_key_col),
        .i_pressed     (i_pressed),
        .i_now_ms      (i_now_ms),
        .i_debounce_ms (r_debounce_ms),
        .i_repeat_ms   (r_repeat_ms),
        .i_q_ready     (w_q_ready),
        .o_push        (w_push),
        .o_word        (w_push_word)
    );

    kprr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_push_word),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_word  (w_head_word)
    );

    // keymap bytes: key k sits in bits 8k+7..8k of {high, low}
    kprr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .o_pop        (w_pop),
        .i_word       (w_head_word),
        .i_keymap     ({r_keymap_high, r_keymap_low}),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_keycode    (o_keycode),
        .o_event_kind (o_event_kind)
    );

endmodule
